// ===== rtl/lrtm_pkg.sv =====
// Shared types, constants and microcode tables for the linear recurrence term core.
// Used by lrtm_dp, lrtm_ctrl, the top level and the checker. No dependencies.
`timescale 1ns / 1ps

package lrtm_pkg;

	localparam int VW        = 31;                      // value width
	localparam int IW        = 31;                      // index width
	localparam int CNTW      = $clog2(VW + 1);          // multiply step counter
	localparam int RFA       = 4;                       // register file address bits
	localparam int RF_DEPTH  = 1 << RFA;
	localparam int PCW       = 7;                       // microcode step counter
	localparam int S_TDATA_W = ((2 * VW + IW + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VW + 7) / 8) * 8;
	localparam int CFG_IW    = 2;

	localparam logic [VW-1:0] P_RESET = VW'(1);
	localparam logic [VW-1:0] Q_RESET = VW'(1);
	localparam logic [VW-1:0] M_RESET = VW'(1000000007);

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_P = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_Q = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_M = 2'd2;

	// register file map: start terms, base matrix, accumulator matrix, scratch matrix
	localparam logic [RFA-1:0] RF_A1 = 4'd0;
	localparam logic [RFA-1:0] RF_A2 = 4'd1;
	localparam logic [RFA-1:0] RF_B  = 4'd2;
	localparam logic [RFA-1:0] RF_C  = 4'd6;
	localparam logic [RFA-1:0] RF_T  = 4'd10;

	typedef enum logic [3:0] {
		OP_NOP, OP_CLR, OP_LDA, OP_LDB, OP_MUL, OP_ADD, OP_LDS, OP_WR, OP_END
	} op_t;

	typedef enum logic [2:0] {
		SRC_RF, SRC_ONE, SRC_ZERO, SRC_P, SRC_Q, SRC_IN1, SRC_IN2
	} src_t;

	typedef enum logic [1:0] {
		PRG_SETUP, PRG_ACC, PRG_SQ, PRG_FINAL
	} prg_t;

	typedef struct packed {
		op_t            op;
		src_t           src;
		logic [RFA-1:0] addr;
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic load_in;
		logic shift_e;
		logic load_out;
		logic bad;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic e_zero;
		logic e_lsb;
		logic n_zero;
	} dp_sts_t;

	function automatic uop_t mk_uop(op_t op, src_t src, logic [RFA-1:0] addr);
		uop_t u;
		u.op   = op;
		u.src  = src;
		u.addr = addr;
		return u;
	endfunction

	// x + y mod m, with x, y < m
	function automatic logic [VW-1:0] add_mod(logic [VW-1:0] x, logic [VW-1:0] y,
			logic [VW-1:0] m);
		logic [VW:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VW-1:0];
	endfunction

	// setup: ten entries of eight steps, each entry reduces one value into the file
	function automatic uop_t setup_uop(logic [PCW-1:0] pc);
		logic [3:0]     k;
		logic [2:0]     st;
		src_t           s;
		logic [RFA-1:0] a;
		uop_t           u;
		k  = pc[6:3];
		st = pc[2:0];
		case (k)
			4'd0:    begin s = SRC_ZERO; a = RF_B;            end
			4'd1:    begin s = SRC_Q;    a = RF_B + 4'd1;     end
			4'd2:    begin s = SRC_ONE;  a = RF_B + 4'd2;     end
			4'd3:    begin s = SRC_P;    a = RF_B + 4'd3;     end
			4'd4:    begin s = SRC_ONE;  a = RF_C;            end
			4'd5:    begin s = SRC_ZERO; a = RF_C + 4'd1;     end
			4'd6:    begin s = SRC_ZERO; a = RF_C + 4'd2;     end
			4'd7:    begin s = SRC_ONE;  a = RF_C + 4'd3;     end
			4'd8:    begin s = SRC_IN1;  a = RF_A1;           end
			4'd9:    begin s = SRC_IN2;  a = RF_A2;           end
			default: begin s = SRC_ZERO; a = RF_A1;           end
		endcase
		case (st)
			3'd0:    u = mk_uop(OP_CLR, SRC_RF, a);
			3'd1:    u = mk_uop(OP_LDA, SRC_ONE, a);
			3'd2:    u = mk_uop(OP_LDB, s, a);
			3'd3:    u = mk_uop(OP_MUL, SRC_RF, a);
			3'd4:    u = mk_uop(OP_ADD, SRC_RF, a);
			3'd5:    u = mk_uop(OP_WR, SRC_RF, a);
			default: u = mk_uop(OP_NOP, SRC_RF, a);
		endcase
		if (k >= 4'd10) begin
			u = mk_uop(OP_END, SRC_RF, a);
		end
		return u;
	endfunction

	// D = X * Y: four entries of sixteen steps into scratch, then copy scratch to D
	function automatic uop_t mm_uop(logic [PCW-1:0] pc, logic [RFA-1:0] xb,
			logic [RFA-1:0] yb, logic [RFA-1:0] db);
		logic           i;
		logic           j;
		logic [RFA-1:0] x0;
		logic [RFA-1:0] x1;
		logic [RFA-1:0] y0;
		logic [RFA-1:0] y1;
		logic [RFA-1:0] t;
		uop_t           u;
		i  = pc[5];
		j  = pc[4];
		x0 = xb + RFA'({i, 1'b0});
		x1 = xb + RFA'({i, 1'b1});
		y0 = yb + RFA'({1'b0, j});
		y1 = yb + RFA'({1'b1, j});
		t  = RF_T + RFA'({i, j});
		if (pc[6]) begin
			if (pc[5:3] != 3'd0) begin
				u = mk_uop(OP_END, SRC_RF, t);
			end else if (!pc[0]) begin
				u = mk_uop(OP_LDS, SRC_RF, RF_T + RFA'(pc[2:1]));
			end else begin
				u = mk_uop(OP_WR, SRC_RF, db + RFA'(pc[2:1]));
			end
		end else begin
			case (pc[3:0])
				4'd0:    u = mk_uop(OP_CLR, SRC_RF, t);
				4'd1:    u = mk_uop(OP_LDA, SRC_RF, x0);
				4'd2:    u = mk_uop(OP_LDB, SRC_RF, y0);
				4'd3:    u = mk_uop(OP_MUL, SRC_RF, t);
				4'd4:    u = mk_uop(OP_ADD, SRC_RF, t);
				4'd5:    u = mk_uop(OP_LDA, SRC_RF, x1);
				4'd6:    u = mk_uop(OP_LDB, SRC_RF, y1);
				4'd7:    u = mk_uop(OP_MUL, SRC_RF, t);
				4'd8:    u = mk_uop(OP_ADD, SRC_RF, t);
				4'd9:    u = mk_uop(OP_WR, SRC_RF, t);
				default: u = mk_uop(OP_NOP, SRC_RF, t);
			endcase
		end
		return u;
	endfunction

	// result = a1 * acc[0][0] + a2 * acc[1][0], left in the sum register
	function automatic uop_t final_uop(logic [PCW-1:0] pc);
		uop_t u;
		case (pc)
			7'd0:    u = mk_uop(OP_CLR, SRC_RF, RF_A1);
			7'd1:    u = mk_uop(OP_LDA, SRC_RF, RF_A1);
			7'd2:    u = mk_uop(OP_LDB, SRC_RF, RF_C);
			7'd3:    u = mk_uop(OP_MUL, SRC_RF, RF_A1);
			7'd4:    u = mk_uop(OP_ADD, SRC_RF, RF_A1);
			7'd5:    u = mk_uop(OP_LDA, SRC_RF, RF_A2);
			7'd6:    u = mk_uop(OP_LDB, SRC_RF, RF_C + 4'd2);
			7'd7:    u = mk_uop(OP_MUL, SRC_RF, RF_A1);
			7'd8:    u = mk_uop(OP_ADD, SRC_RF, RF_A1);
			default: u = mk_uop(OP_END, SRC_RF, RF_A1);
		endcase
		return u;
	endfunction

	function automatic uop_t prg_uop(prg_t prg, logic [PCW-1:0] pc);
		uop_t u;
		case (prg)
			PRG_SETUP: u = setup_uop(pc);
			PRG_ACC:   u = mm_uop(pc, RF_C, RF_B, RF_C);
			PRG_SQ:    u = mm_uop(pc, RF_B, RF_B, RF_B);
			PRG_FINAL: u = final_uop(pc);
			default:   u = mk_uop(OP_END, SRC_RF, RF_A1);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/lrtm_dp.sv =====
// Datapath: configuration registers, operand register file, serial modular
// multiplier, sum register, exponent shifter and result register. Uses lrtm_pkg.
`timescale 1ns / 1ps

module lrtm_dp import lrtm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [VW-1:0]     cfg_data,
	input  logic [VW-1:0]     in_first,
	input  logic [VW-1:0]     in_second,
	input  logic [IW-1:0]     in_index,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic [VW-1:0]     term_value,
	output logic              bad_index
);

	logic [VW-1:0]   p_q, q_q, m_q;
	logic [VW-1:0]   in1_q, in2_q;
	logic [IW-1:0]   e_q;
	logic            n_zero_q;
	logic [VW-1:0]   rf_q [RF_DEPTH];
	logic [VW-1:0]   a_q, b_q, prod_q, sum_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW-1:0]   term_q;
	logic            bad_q;

	logic [VW-1:0]   m_eff;
	logic [VW-1:0]   one_m;
	logic [VW-1:0]   rd;
	logic [VW-1:0]   opnd;
	logic [VW-1:0]   dbl;
	logic            busy;

	// zero modulus behaves as one
	assign m_eff = (m_q == '0) ? VW'(1) : m_q;
	assign one_m = (m_eff == VW'(1)) ? '0 : VW'(1);
	assign rd    = rf_q[cmd.uop.addr];
	assign busy  = (cnt_q != '0);

	// operand select
	always_comb begin
		case (cmd.uop.src)
			SRC_RF:   opnd = rd;
			SRC_ONE:  opnd = one_m;
			SRC_ZERO: opnd = '0;
			SRC_P:    opnd = p_q;
			SRC_Q:    opnd = q_q;
			SRC_IN1:  opnd = in1_q;
			SRC_IN2:  opnd = in2_q;
			default:  opnd = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= P_RESET;
			q_q <= Q_RESET;
			m_q <= M_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_P:   p_q <= cfg_data;
				CFG_Q:   q_q <= cfg_data;
				CFG_M:   m_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input capture and exponent
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in1_q    <= in_first;
			in2_q    <= in_second;
			e_q      <= in_index - IW'(1);
			n_zero_q <= (in_index == '0);
		end else if (cmd.shift_e) begin
			e_q <= e_q >> 1;
		end
	end

	// register file write
	always_ff @(posedge clk) begin
		if (cmd.uop.op == OP_WR) begin
			rf_q[cmd.uop.addr] <= sum_q;
		end
	end

	// multiplier step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.uop.op == OP_MUL) begin
			cnt_q <= CNTW'(VW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	// shift-and-add product, most significant bit of b first
	assign dbl = add_mod(prod_q, prod_q, m_eff);

	always_ff @(posedge clk) begin
		case (cmd.uop.op)
			OP_LDA: a_q <= opnd;
			OP_LDB: b_q <= opnd;
			OP_MUL: prod_q <= '0;
			OP_CLR: sum_q <= '0;
			OP_ADD: sum_q <= add_mod(sum_q, prod_q, m_eff);
			OP_LDS: sum_q <= rd;
			default: ;
		endcase
		if (busy) begin
			prod_q <= add_mod(dbl, b_q[VW-1] ? a_q : '0, m_eff);
			b_q    <= b_q << 1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			term_q <= cmd.bad ? '0 : sum_q;
			bad_q  <= cmd.bad;
		end
	end

	assign sts.mul_busy = busy;
	assign sts.e_zero   = (e_q == '0);
	assign sts.e_lsb    = e_q[0];
	assign sts.n_zero   = n_zero_q;
	assign term_value   = term_q;
	assign bad_index    = bad_q;

endmodule

// ===== rtl/lrtm_ctrl.sv =====
// Controller: microcode sequencer that walks setup, matrix multiply, squaring
// and final programs over the exponent bits, and runs both handshakes. Uses lrtm_pkg.
`timescale 1ns / 1ps

module lrtm_ctrl import lrtm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_TEST  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]     state_q, state_d;
	prg_t           prg_q, prg_d;
	logic [PCW-1:0] pc_q, pc_d;
	logic           bad_q, bad_d;
	logic           out_valid_q;
	uop_t           u;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign u         = prg_uop(prg_q, pc_q);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		prg_d        = prg_q;
		pc_d         = pc_q;
		bad_d        = bad_q;
		cmd          = '0;
		cmd.load_in  = in_valid && in_ready;
		cmd.bad      = bad_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
					prg_d   = PRG_SETUP;
					pc_d    = '0;
				end
			end
			S_EXEC: begin
				if (u.op == OP_END) begin
					pc_d = '0;
					case (prg_q)
						PRG_SETUP: state_d = S_TEST;
						PRG_ACC:   prg_d = PRG_SQ;
						PRG_SQ:    state_d = S_SHIFT;
						PRG_FINAL: state_d = S_DONE;
						default:   state_d = S_IDLE;
					endcase
				end else begin
					cmd.uop = u;
					if (u.op == OP_MUL) begin
						state_d = S_WAIT;
					end else begin
						pc_d = pc_q + PCW'(1);
					end
				end
			end
			S_WAIT: begin
				if (!sts.mul_busy) begin
					state_d = S_EXEC;
					pc_d    = pc_q + PCW'(1);
				end
			end
			S_TEST: begin
				pc_d  = '0;
				bad_d = sts.n_zero;
				if (sts.n_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_EXEC;
					if (sts.e_zero) begin
						prg_d = PRG_FINAL;
					end else if (sts.e_lsb) begin
						prg_d = PRG_ACC;
					end else begin
						prg_d = PRG_SQ;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift_e = 1'b1;
				state_d     = S_TEST;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prg_q       <= PRG_SETUP;
			pc_q        <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			prg_q       <= prg_d;
			pc_q        <= pc_d;
			bad_q       <= bad_d;
			out_valid_q <= cmd.load_out || (out_valid_q && !out_ready);
		end
	end

endmodule

// ===== rtl/linear_recurrence_term_mod_core.sv =====
// Top level of the linear recurrence term core: stream ports, configuration
// port, controller and datapath. Uses lrtm_pkg, lrtm_ctrl and lrtm_dp.
`timescale 1ns / 1ps

// Returns term n of a(k) = p*a(k-1) + q*a(k-2) mod m from a(1), a(2) and n by
// raising the 2x2 companion matrix to the power n-1 with square-and-multiply.
// One item is worked on at a time. All arithmetic runs on one bit-serial
// modular multiplier. An item takes a setup pass that reduces the operands,
// bitlength(n-1) + popcount(n-1) matrix products and a final pass. Index zero
// is answered after the setup pass with bad_index set and a term of zero. A
// finished result sits in an output register, so the next item can be
// accepted before it is taken.
// Registers (cfg_index): 0 coeff_last, 1 coeff_before_last, 2 modulus; a
// modulus of zero acts as one. Write them only while the core is idle.

module linear_recurrence_term_mod_core import lrtm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // first_term, second_term, term_index, pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // term_value, pad
	output logic [0:0]           m_tuser,   // bad_index
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [VW-1:0]        cfg_data
);

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [VW-1:0] term_value;
	logic          bad_index;

	assign cfg_ready = 1'b1;

	lrtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lrtm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_first   (s_tdata[VW-1:0]),
		.in_second  (s_tdata[2*VW-1:VW]),
		.in_index   (s_tdata[2*VW+IW-1:2*VW]),
		.cmd        (cmd),
		.sts        (sts),
		.term_value (term_value),
		.bad_index  (bad_index)
	);

	// output packing
	assign m_tdata    = {{(M_TDATA_W - VW){1'b0}}, term_value};
	assign m_tuser[0] = bad_index;

endmodule

// ===== rtl/lrtm_checker.sv =====
// Port-level checks for the linear recurrence term core, bound to the top level.
// Uses lrtm_pkg.
`timescale 1ns / 1ps

module lrtm_checker import lrtm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IW-1:0]    cfg_index,
	input logic [VW-1:0]        cfg_data
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// a bad index always carries a zero term
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("bad index with non-zero term");

	// padding above the term stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:VW] == '0)
		else $error("term padding not zero");

	// one item at a time: no transaction straight after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

endmodule

bind linear_recurrence_term_mod_core lrtm_checker u_lrtm_checker (.*);

// ===== test/lrtm_checker.sv =====
// Checker for the linear recurrence term core: watches the stream and
// configuration channels, predicts each term and compares. Uses lrtm_pkg.
`timescale 1ns / 1ps

module tb_lrtm_checker import lrtm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // first_term, second_term, term_index, pad
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // term_value, pad
	input  logic [0:0]           m_tuser,   // bad_index
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [VW-1:0]        cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [VW-1:0] term_value;
		logic          bad_index;
	} term_res_t;

	term_res_t     exp_terms[$];
	logic [VW-1:0] coeff_p;
	logic [VW-1:0] coeff_q;
	logic [VW-1:0] modulus;

	// term n of the recurrence mod m, by squaring the companion matrix
	function automatic term_res_t predict_term(logic [VW-1:0] a1_in, logic [VW-1:0] a2_in,
			logic [IW-1:0] n, logic [VW-1:0] p, logic [VW-1:0] q, logic [VW-1:0] m_in);
		logic [63:0] m, a1, a2, e;
		logic [63:0] b00, b01, b10, b11, c00, c01, c10, c11, t00, t01, t10, t11;
		term_res_t   r;
		m  = (m_in == '0) ? 64'd1 : 64'(m_in);
		a1 = 64'(a1_in) % m;
		a2 = 64'(a2_in) % m;
		if (n == '0) begin
			r.term_value = '0;
			r.bad_index  = 1'b1;
			return r;
		end
		b00 = 0;        b01 = 64'(q) % m;
		b10 = 1 % m;    b11 = 64'(p) % m;
		c00 = 1 % m;    c01 = 0;
		c10 = 0;        c11 = 1 % m;
		e = 64'(n) - 1;
		while (e != 0) begin
			if (e[0]) begin
				t00 = (c00 * b00 + c01 * b10) % m;
				t01 = (c00 * b01 + c01 * b11) % m;
				t10 = (c10 * b00 + c11 * b10) % m;
				t11 = (c10 * b01 + c11 * b11) % m;
				c00 = t00; c01 = t01; c10 = t10; c11 = t11;
			end
			t00 = (b00 * b00 + b01 * b10) % m;
			t01 = (b00 * b01 + b01 * b11) % m;
			t10 = (b10 * b00 + b11 * b10) % m;
			t11 = (b10 * b01 + b11 * b11) % m;
			b00 = t00; b01 = t01; b10 = t10; b11 = t11;
			e = e >> 1;
		end
		r.term_value = VW'((a1 * c00 + a2 * c10) % m);
		r.bad_index  = 1'b0;
		return r;
	endfunction

	// results first, so a result and a new item on one edge keep their order
	always @(posedge clk or negedge arst_n) begin
		term_res_t want;
		if (!arst_n) begin
			coeff_p <= P_RESET;
			coeff_q <= Q_RESET;
			modulus <= M_RESET;
			errors  <= 0;
			pending <= 0;
			exp_terms.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (exp_terms.size() == 0) begin
					$display("%0t: unexpected result term=%0d bad=%0d", $time,
						m_tdata[VW-1:0], m_tuser);
					errors <= errors + 1;
				end else begin
					want = exp_terms.pop_front();
					if (m_tdata[VW-1:0] !== want.term_value || m_tuser[0] !== want.bad_index) begin
						$display("%0t: mismatch expected term=%0d bad=%0d actual term=%0d bad=%0d",
							$time, want.term_value, want.bad_index, m_tdata[VW-1:0], m_tuser);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				exp_terms.push_back(predict_term(s_tdata[VW-1:0], s_tdata[2*VW-1:VW],
					s_tdata[2*VW+IW-1:2*VW], coeff_p, coeff_q, modulus));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_P:   coeff_p <= cfg_data;
					CFG_Q:   coeff_q <= cfg_data;
					CFG_M:   modulus <= cfg_data;
					default: ;
				endcase
			end
			pending <= exp_terms.size();
		end
	end

endmodule

// ===== test/tb_linear_recurrence_term_mod_core.sv =====
// Testbench top for the linear recurrence term core: clock, reset, stimulus
// and verdict. Depends on lrtm_pkg, the core and tb_lrtm_checker.
`timescale 1ns / 1ps

module tb_linear_recurrence_term_mod_core;
	import lrtm_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam logic [VW-1:0] VMAX = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // first_term, second_term, term_index, pad
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // term_value, pad
	logic [0:0]           m_tuser;        // bad_index
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IW-1:0]    cfg_index = CFG_P;
	logic [VW-1:0]        cfg_data = '0;
	int                   errors;
	int                   pending;
	int                   burst_left = 0;
	int                   idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	linear_recurrence_term_mod_core i_dut (.*);

	tb_lrtm_checker i_checker (.*);

	// receiver: alternates between always-ready stretches and random stalls
	always @(posedge clk) begin
		int mode_left;
		int mode;
		if (mode_left <= 0) begin
			mode      = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 400);
		end
		mode_left = mode_left - 1;
		case (mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_linear_recurrence_term_mod_core: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one input item, with bursts and random gaps in between; starts and ends at a rising edge
	task automatic send_term(logic [VW-1:0] a1, logic [VW-1:0] a2, logic [IW-1:0] n);
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 6);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		burst_left = burst_left - 1;
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({n, a2, a1});
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || m_tvalid) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one register write; the caller drops cfg_valid after the last one
	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [VW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic set_coeffs(logic [VW-1:0] p, logic [VW-1:0] q, logic [VW-1:0] m);
		write_reg(CFG_P, p);
		write_reg(CFG_Q, q);
		write_reg(CFG_M, m);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random items: mostly short indexes, now and then a full-width one
	task automatic random_terms(int count);
		logic [IW-1:0] n;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 19))
				0:       n = '0;
				1:       n = IW'($urandom);
				2, 3:    n = IW'($urandom_range(0, 4096));
				default: n = IW'($urandom_range(1, 40));
			endcase
			send_term(VW'($urandom), VW'($urandom), n);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset coefficients: plain Fibonacci mod 1e9+7
		send_term(1, 1, 0);
		send_term(1, 1, 1);
		send_term(5, 9, 2);
		send_term(1, 1, 3);
		send_term(1, 1, 10);
		send_term(VMAX, VMAX, 1);
		send_term(VMAX, VMAX, 2);
		send_term(VMAX, VMAX, 50);
		send_term(0, 0, 17);
		send_term(0, VMAX, {IW{1'b1}});
		send_term(3, 7, {1'b1, {(IW-1){1'b0}}});
		drain();

		// extremes of the coefficients and modulus
		set_coeffs(VMAX, VMAX, VMAX);
		send_term(VMAX, VMAX, 5);
		send_term(VMAX - 1, 2, {IW{1'b1}});
		send_term(1, 0, 0);
		drain();
		set_coeffs(0, 0, 1);
		send_term(VMAX, 4, 9);
		send_term(VMAX, 4, 1);
		drain();
		set_coeffs(3, 2, 0);
		send_term(VMAX, 12, 7);
		send_term(5, 5, 2);
		send_term(0, 0, 0);
		drain();
		set_coeffs(0, 5, 13);
		send_term(20, 30, 6);
		send_term(100, 200, 1);
		drain();

		// random phases with random settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       set_coeffs(VW'($urandom), VW'($urandom), VW'($urandom));
				1:       set_coeffs(VW'($urandom_range(0, 9)), VW'($urandom_range(0, 9)),
							VW'($urandom_range(1, 50)));
				2:       set_coeffs(VW'($urandom), VW'($urandom), VMAX);
				default: set_coeffs(P_RESET, Q_RESET, M_RESET);
			endcase
			random_terms(25);
			drain();
		end

		if (errors == 0) begin
			$display("tb_linear_recurrence_term_mod_core: PASS");
		end else begin
			$display("tb_linear_recurrence_term_mod_core: FAIL");
		end
		$finish;
	end

endmodule
